>>> hw/rtl/lru_cache_expiry_table_top_macros.svh
// Assertion macros used by the LRU cache expiry table top level.
`ifndef LRU_CACHE_EXPIRY_TABLE_TOP_MACROS_SVH
`define LRU_CACHE_EXPIRY_TABLE_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LCET_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LCET_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/lcet_pkg.sv
// Package with the types and codes of the LRU cache expiry table.
`default_nettype none
package lcet_pkg;

  // Request codes.
  localparam logic [1:0] REQ_FETCH  = 2'd0;
  localparam logic [1:0] REQ_STORE  = 2'd1;
  localparam logic [1:0] REQ_UPDATE = 2'd2;

  // Result outcome codes.
  localparam logic [2:0] OC_MISS       = 3'd0;
  localparam logic [2:0] OC_EXPIRED    = 3'd1;
  localparam logic [2:0] OC_REVALIDATE = 3'd2;
  localparam logic [2:0] OC_VALID      = 3'd3;
  localparam logic [2:0] OC_STORED     = 3'd4;
  localparam logic [2:0] OC_STORE_SKIP = 3'd5;
  localparam logic [2:0] OC_UPDATED    = 3'd6;
  localparam logic [2:0] OC_UPDATE_SKIP = 3'd7;

  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

  // One cached entry as held in a cell.
  typedef struct packed {
    logic        vld;
    logic [63:0] key;
    logic [31:0] payload;
    logic [31:0] expiry;
    logic        reval;
  } entry_t;

  // Per-cell control strobes.
  typedef struct packed {
    logic shift;
    logic upd;
    logic clr;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_APPLY,
    ST_TRIM,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

>>> hw/rtl/lcet_cell.sv
// One recency slot of the table: holds an entry and compares its key.
`default_nettype none
module lcet_cell
  import lcet_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cell_ctl_t   ctl,
  input  wire entry_t      prev_ent,
  input  wire logic [63:0] cmp_key,
  input  wire logic [31:0] upd_expiry,
  input  wire logic        upd_reval,
  output entry_t           ent,
  output logic             match
);

  entry_t ent_r;

  // Take the neighbour's entry on a shift, else refresh or drop in place.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.vld <= 1'b0;
    end else if (ctl.shift) begin
      ent_r <= prev_ent;
    end else begin
      if (ctl.upd) begin
        ent_r.expiry <= upd_expiry;
        ent_r.reval  <= upd_reval;
      end
      if (ctl.clr) begin
        ent_r.vld <= 1'b0;
      end
    end
  end

  assign ent   = ent_r;
  assign match = ent_r.vld && (ent_r.key == cmp_key);

endmodule
`default_nettype wire

>>> hw/rtl/lru_cache_expiry_table_top.sv
// Top level of the LRU cache expiry table: controller and the row of cells.
//
//  Channel | Direction | Handshake               | Payload
//  in_     | input     | in_valid / in_ready     | req_type, key_tag, times, flags, payload
//  out_    | output    | out_valid / out_ready   | outcome, payload, expiry, eviction
//  cfg_    | input     | cfg_wr_en (no wait)     | capacity
//
// Each beat passes through the controller states in order: capture (IDLE), tag compare
// (LOOK), shift of the cell row (APPLY), trim against capacity (TRIM), and load of the output register (DONE).
// A new beat is taken while a finished result still waits in the output register.
// Reset is synchronous and active low; it empties every cell and restores capacity 10.
// A stalled output holds the controller in its last step until the result is taken.
`default_nettype none
module lru_cache_expiry_table_top
  import lcet_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_req_type,
  input  wire logic [63:0]       in_key_tag,
  input  wire logic [31:0]       in_now_time,
  input  wire logic [31:0]       in_expire_time,
  input  wire logic              in_must_revalidate,
  input  wire logic              in_cacheable,
  input  wire logic              in_status_ok,
  input  wire logic [31:0]       in_payload,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             out_outcome,
  output logic [31:0]            out_cached_payload,
  output logic [31:0]            out_expire_out,
  output logic                   out_evicted,
  output logic [63:0]            out_evicted_key,
  input  wire logic              cfg_wr_en,
  input  wire logic [CAP_W-1:0]  cfg_wr_data
);

  `include "lru_cache_expiry_table_top_macros.svh"

  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  state_t state_r, state_nxt;

  // Captured request.
  logic [1:0]  req_r;
  logic [63:0] key_r;
  logic [31:0] now_r, exp_r, pay_r;
  logic        reval_r, cach_r, ok_r;

  logic [CAP_W-1:0] cap_r;
  logic [CW-1:0]    count_r;

  // Compare results.
  logic                   hit_r;
  logic [MAX_ENTRIES-1:0] hit_oh_r, le_r;
  entry_t                 hit_ent_r;

  // Pending result.
  logic [2:0]  res_outcome_r;
  logic [31:0] res_pay_r, res_exp_r;
  logic        res_ev_r;
  logic [63:0] res_evkey_r;

  logic        out_valid_r;
  logic [2:0]  out_outcome_r;
  logic [31:0] out_pay_r, out_exp_r;
  logic        out_ev_r;
  logic [63:0] out_evkey_r;

  // Controller strobes.
  logic accept, look_en, apply_en, trim_en, done_load;

  entry_t                 ents [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] match_vec, vld_vec;
  cell_ctl_t              ctls [MAX_ENTRIES];
  entry_t                 front_ent;

  logic [MAX_ENTRIES-1:0] le_nxt;
  entry_t                 hit_ent_nxt;
  logic                   store_go, store_new, full, trim_need;
  logic [CMPW-1:0]        cap_lim;
  logic [63:0]            tail_key;

  // Row of cells, each handing its entry to the next one down.
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    lcet_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctls[i]),
      .prev_ent   ((i == 0) ? front_ent : ents[(i == 0) ? 0 : i - 1]),
      .cmp_key    (key_r),
      .upd_expiry (exp_r),
      .upd_reval  (reval_r),
      .ent        (ents[i]),
      .match      (match_vec[i])
    );
    assign vld_vec[i] = ents[i].vld;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_LOOK;
      ST_LOOK:  state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = ST_TRIM;
      ST_TRIM:  state_nxt = ST_DONE;
      ST_DONE:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_ready  = 1'b0;
    look_en   = 1'b0;
    apply_en  = 1'b0;
    trim_en   = 1'b0;
    done_load = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ready  = 1'b1;
      ST_LOOK:  look_en   = 1'b1;
      ST_APPLY: apply_en  = 1'b1;
      ST_TRIM:  trim_en   = 1'b1;
      ST_DONE:  done_load = !out_valid_r || out_ready;
      default:  in_ready  = 1'b0;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r   <= in_req_type;
      key_r   <= in_key_tag;
      now_r   <= in_now_time;
      exp_r   <= in_expire_time;
      reval_r <= in_must_revalidate;
      cach_r  <= in_cacheable;
      ok_r    <= in_status_ok;
      pay_r   <= in_payload;
    end
  end

  // Hit position as a mask of itself and every more recent slot, and the hit entry.
  always_comb begin
    hit_ent_nxt = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      le_nxt[i] = |(match_vec >> i);
      if (match_vec[i]) begin
        hit_ent_nxt = hit_ent_nxt | ents[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (look_en) begin
      hit_r     <= |match_vec;
      hit_oh_r  <= match_vec;
      le_r      <= le_nxt;
      hit_ent_r <= hit_ent_nxt;
    end
  end

  assign store_go  = (req_r == REQ_STORE) && ok_r && cach_r;
  assign store_new = store_go && !hit_r;
  assign full      = (count_r == CW'(MAX_ENTRIES));
  assign cap_lim   = (cap_r == '0) ? CMPW'(1) : CMPW'(cap_r);
  assign trim_need = (res_outcome_r == OC_STORED) && !res_ev_r &&
                     (CMPW'(count_r) > cap_lim);

  // Entry presented to the head of the row.
  always_comb begin
    front_ent = hit_ent_r;
    if (store_go) begin
      front_ent.vld     = 1'b1;
      front_ent.key     = key_r;
      front_ent.payload = pay_r;
      front_ent.expiry  = exp_r;
      front_ent.reval   = reval_r;
    end
  end

  // Key of the least recent valid entry, used when trimming.
  always_comb begin
    tail_key = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (count_r == CW'(i + 1)) begin
        tail_key = ents[i].key;
      end
    end
  end

  // Per-cell control.
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      ctls[i].shift = apply_en && (store_new ||
                      (hit_r && (store_go || req_r == REQ_FETCH)) && le_r[i]);
      ctls[i].upd   = apply_en && (req_r == REQ_UPDATE) && cach_r && hit_oh_r[i];
      ctls[i].clr   = trim_en && trim_need && (count_r == CW'(i + 1));
    end
  end

  // Fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (apply_en && store_new && !full) begin
      count_r <= count_r + CW'(1);
    end else if (trim_en && trim_need) begin
      count_r <= count_r - CW'(1);
    end
  end

  // Result of the operation, then of the trim against capacity.
  always_ff @(posedge clk) begin
    if (apply_en) begin
      res_pay_r   <= '0;
      res_exp_r   <= '0;
      res_ev_r    <= 1'b0;
      res_evkey_r <= '0;
      case (req_r)
        REQ_FETCH: begin
          if (hit_r) begin
            res_pay_r <= hit_ent_r.payload;
            res_exp_r <= hit_ent_r.expiry;
            if (now_r > hit_ent_r.expiry) begin
              res_outcome_r <= OC_EXPIRED;
            end else if (hit_ent_r.reval) begin
              res_outcome_r <= OC_REVALIDATE;
            end else begin
              res_outcome_r <= OC_VALID;
            end
          end else begin
            res_outcome_r <= OC_MISS;
          end
        end
        REQ_STORE: begin
          res_outcome_r <= store_go ? OC_STORED : OC_STORE_SKIP;
          if (store_new && full) begin
            res_ev_r    <= 1'b1;
            res_evkey_r <= ents[MAX_ENTRIES-1].key;
          end
        end
        REQ_UPDATE: begin
          res_outcome_r <= (hit_r && cach_r) ? OC_UPDATED : OC_UPDATE_SKIP;
        end
        default: res_outcome_r <= OC_MISS;
      endcase
    end else if (trim_en && trim_need) begin
      res_ev_r    <= 1'b1;
      res_evkey_r <= tail_key;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_load) begin
      out_outcome_r <= res_outcome_r;
      out_pay_r     <= res_pay_r;
      out_exp_r     <= res_exp_r;
      out_ev_r      <= res_ev_r;
      out_evkey_r   <= res_evkey_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_outcome        = out_outcome_r;
  assign out_cached_payload = out_pay_r;
  assign out_expire_out     = out_exp_r;
  assign out_evicted        = out_ev_r;
  assign out_evicted_key    = out_evkey_r;

  // Valid entries stay packed at the most recent end of the row.
  `LCET_ASSERT_IMP(a_packed, 1'b1, ((vld_vec >> 1) & ~vld_vec) == '0, "cell row not packed")
  // The fill count matches the number of valid cells.
  `LCET_ASSERT_IMP(a_count, 1'b1, $countones(vld_vec) == int'(count_r), "fill count mismatch")
  // Keys are unique, so at most one cell matches.
  `LCET_ASSERT_IMP(a_onehit, look_en, $onehot0(match_vec), "several cells hit")
  // Only a store reports an eviction.
  `LCET_ASSERT_IMP(a_evstore, out_valid_r && out_ev_r, out_outcome_r == OC_STORED,
    "eviction without store")
  // A store that goes ahead, new or a hit, leaves at least one entry.
  `LCET_ASSERT_NXT(a_nonempty, apply_en && store_go, count_r != '0, "store left table empty")

endmodule
`default_nettype wire
